@@ hw/rtl/tdw_pkg.sv @@
// Shared widths, reset values and event codes for the travel distance watchdog.
// No dependencies; imported by tdw_isqrt and travel_distance_watchdog.
`default_nettype none

package tdw_pkg;

    localparam int POS_WIDTH = 24;                 // signed position width
    localparam int ACC_WIDTH = 32;                 // travelled accumulator width
    localparam int CFG_WIDTH = 32;                 // max_distance register width

    localparam logic [CFG_WIDTH-1:0] MAX_DIST_RESET = CFG_WIDTH'(1280); // 5.0 m

    localparam int DIFF_W = POS_WIDTH + 1;         // |dx|, |dy| unsigned
    localparam int PROD_W = 2 * DIFF_W;            // one square
    localparam int ROOT_W = POS_WIDTH + 2;         // root of dx^2 + dy^2
    localparam int RAD_W  = 2 * ROOT_W;            // radicand, even width
    localparam int REM_W  = ROOT_W + 2;            // sqrt partial remainder
    localparam int SUM_W  = ((ACC_WIDTH > ROOT_W) ? ACC_WIDTH : ROOT_W) + 1;
    localparam int CMP_W  = (ACC_WIDTH > CFG_WIDTH) ? ACC_WIDTH : CFG_WIDTH;
    localparam int ITER_W = $clog2(ROOT_W + 1);

    typedef enum logic [1:0] {
        KIND_POS      = 2'd0,
        KIND_LANDMARK = 2'd1,
        KIND_ENABLE   = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

endpackage

`default_nettype wire

@@ hw/rtl/tdw_isqrt.sv @@
// Iterative floor square root, two radicand bits per cycle.
// Depends on tdw_pkg for RAD_W, ROOT_W, REM_W and ITER_W.
`default_nettype none

module tdw_isqrt
    import tdw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ITER_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = ITER_W'(ROOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ hw/rtl/travel_distance_watchdog.sv @@
// Top level of the travel distance watchdog: event decode, shared squarer,
// sequencer and state. Depends on tdw_pkg and tdw_isqrt.
`default_nettype none

// Usage
//   s_* channel: one event beat per handshake. s_kind selects position sample,
//     landmark seen, or enable event; unused fields are ignored.
//   m_* channel: one beat per position sample carrying m_stop_flag, the stop
//     state as it stood before that sample was applied. Other events give none.
//   cfg_* channel: writes max_distance (1/256 m); always ready. Write it only
//     while the block is idle.
// Timing
//   Landmark, enable and unused events are applied in the accept cycle and
//   leave s_ready high. A position sample with monitoring off goes from the
//   accept cycle straight to the emit step; with monitoring on it runs through
//   the accept cycle, two passes through one squarer, an add, the root step
//   (start, load, ROOT_W (26) bit-pair iterations, done), a saturating add,
//   a compare and the emit step. s_ready is low while a sample is in flight.
// Reset
//   aresetn (sync, active low) clears enable, total, last position, the stop
//   latch and the output beat, and sets max_distance to 5.0 m.
// Back-pressure
//   The result sits in an output register. A finished sample waits in the
//   emit step while the previous beat is unaccepted; no beat is lost.

module travel_distance_watchdog
    import tdw_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_kind,
    input  wire logic signed [POS_WIDTH-1:0] s_pos_x,
    input  wire logic signed [POS_WIDTH-1:0] s_pos_y,
    input  wire logic                        s_enable_value,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_stop_flag,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_WIDTH-1:0]        cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ADD,
        ST_ROOT,
        ST_ACC,
        ST_CMP,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CFG_WIDTH-1:0]    max_dist_reg;
    logic                    enabled_reg;
    logic [ACC_WIDTH-1:0]    travelled_reg;
    logic [POS_WIDTH-1:0]    last_x_reg;
    logic [POS_WIDTH-1:0]    last_y_reg;
    logic                    stop_reg;
    logic                    flag_hold_reg;     // stop state captured at accept
    logic [DIFF_W-1:0]       ax_reg;
    logic [DIFF_W-1:0]       ay_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic                    m_valid_reg;
    logic                    m_flag_reg;
    logic                    root_start_reg;

    logic                    s_fire;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [DIFF_W-1:0]       ax, ay;
    logic [DIFF_W-1:0]       mul_op;
    logic [PROD_W-1:0]       mul_res;
    logic                    root_done;
    logic [ROOT_W-1:0]       root;
    logic [SUM_W-1:0]        acc_sum;
    logic                    emit_ok;
    logic                    emit_fire;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign emit_ok   = !m_valid_reg || m_ready;
    assign emit_fire = (state_reg == ST_EMIT) && emit_ok;

    // step from the last recorded position; 25-bit difference never overflows
    assign dx = DIFF_W'(s_pos_x) - DIFF_W'($signed(last_x_reg));
    assign dy = DIFF_W'(s_pos_y) - DIFF_W'($signed(last_y_reg));
    assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

    // one squarer, used for x then y
    assign mul_op  = (state_reg == ST_SQX) ? ax_reg : ay_reg;
    assign mul_res = mul_op * mul_op;

    assign acc_sum = SUM_W'(travelled_reg) + SUM_W'(root);

    tdw_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start_reg),
        .radicand (rad_reg),
        .done     (root_done),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            max_dist_reg   <= MAX_DIST_RESET;
            enabled_reg    <= 1'b0;
            travelled_reg  <= '0;
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            stop_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            root_start_reg <= 1'b0;
        end else begin
            root_start_reg <= (state_reg == ST_ADD);
            if (cfg_valid && cfg_ready) begin
                max_dist_reg <= cfg_data;
            end
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (kind_t'(s_kind))
                            KIND_POS: begin
                                flag_hold_reg <= stop_reg;
                                ax_reg        <= ax;
                                ay_reg        <= ay;
                                last_x_reg    <= s_pos_x;
                                last_y_reg    <= s_pos_y;
                                if (enabled_reg) begin
                                    state_reg <= ST_SQX;
                                end else begin
                                    travelled_reg <= '0;
                                    state_reg     <= ST_EMIT;
                                end
                            end
                            KIND_LANDMARK: begin
                                travelled_reg <= '0;
                                stop_reg      <= 1'b0;
                            end
                            KIND_ENABLE: begin
                                enabled_reg <= s_enable_value;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SQX: begin
                    prod_reg  <= mul_res;
                    state_reg <= ST_SQY;
                end
                ST_SQY: begin
                    rad_reg   <= RAD_W'(prod_reg);
                    prod_reg  <= mul_res;
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    rad_reg   <= rad_reg + RAD_W'(prod_reg);
                    state_reg <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (root_done) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    // saturate at all ones
                    if (|acc_sum[SUM_W-1:ACC_WIDTH]) begin
                        travelled_reg <= '1;
                    end else begin
                        travelled_reg <= acc_sum[ACC_WIDTH-1:0];
                    end
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (CMP_W'(travelled_reg) > CMP_W'(max_dist_reg)) begin
                        stop_reg <= 1'b1;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_ok) begin
                        m_flag_reg <= flag_hold_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_stop_flag = m_flag_reg;

endmodule

`default_nettype wire
